// ===== src/cfv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfv_pkg
// Types, codes and constants shared by the configuration frame validator.
// ----------------------------------------------------------------------------
package cfv_pkg;

    localparam int BYTE_W       = 8;
    localparam int STATUS_W     = 3;
    localparam int CFG_INDEX_W  = 2;
    localparam int BYTES_LEFT_W = 10;

    localparam int RECORD_BYTES_DEF = 3;

    localparam logic [BYTE_W-1:0] CRC_POLY  = 8'h8C;
    localparam logic [BYTE_W-1:0] CRC_INIT  = 8'h00;
    localparam logic [BYTE_W-1:0] LSB_MASK  = 8'h01;

    localparam logic [BYTE_W-1:0] START_FLAG_RST    = 8'd250;
    localparam logic [BYTE_W-1:0] END_FLAG_RST      = 8'd175;
    localparam logic [BYTE_W-1:0] BOARD_ADDRESS_RST = 8'd1;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_FLAG    = 2'd0,
        REG_END_FLAG      = 2'd1,
        REG_BOARD_ADDRESS = 2'd2
    } t_reg_index;

    // frame status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_START = 3'd1,
        ST_BAD_ADDR  = 3'd2,
        ST_BAD_CRC   = 3'd3,
        ST_BAD_END   = 3'd4
    } t_status;

endpackage

`default_nettype wire

// ===== src/cfv_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfv_if
// Valid/ready channels of the frame validator: received bytes, frame results
// and configuration writes.
// ----------------------------------------------------------------------------
interface cfv_rx_if import cfv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfv_res_if import cfv_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   frame_address;
    logic [BYTE_W-1:0]   record_count;

    modport source (output valid, output status, output frame_address,
                    output record_count, input ready);
    modport sink   (input valid, input status, input frame_address,
                    input record_count, output ready);
endinterface

interface cfv_cfg_if import cfv_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [BYTE_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/cfv_crc8.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfv_crc8
// One-byte update of a reflected CRC-8, LSB first, no final xor.
// ----------------------------------------------------------------------------
module cfv_crc8 import cfv_pkg::*; (
    input  wire logic [BYTE_W-1:0] i_crc,
    input  wire logic [BYTE_W-1:0] i_data,
    output logic      [BYTE_W-1:0] o_crc
);

    always_comb begin
        logic [BYTE_W-1:0] crc;
        logic [BYTE_W-1:0] data;
        crc  = i_crc;
        data = i_data;
        for (int k = 0; k < BYTE_W; k++) begin
            if (((crc ^ data) & LSB_MASK) != '0) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
            data = data >> 1;
        end
        o_crc = crc;
    end

endmodule

`default_nettype wire

// ===== src/config_frame_validator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// config_frame_validator
// Byte-wise checker for configuration frames with a CRC-8 over the records.
// ----------------------------------------------------------------------------
// Usage:
//   i_rx  : one frame byte per beat, in order: start flag, board address,
//           record count, count * RECORD_BYTES record bytes, CRC, end flag.
//   o_res : one beat per frame, issued for the end byte, carrying the status
//           (bad start, bad address, bad CRC, bad end in that priority, else ok)
//           with the address and record count taken from the frame.
//   i_cfg : register writes (start flag, end flag, board address); always
//           ready, meant to be used while no frame is in flight.
// Throughput: one byte per cycle. Each byte updates the frame state in the
//   cycle it is accepted: one unrolled CRC byte step and a count step.
// Latency: the result beat is valid the cycle after the end byte is taken.
// Stall: the result register holds while o_res.ready is low; bytes other
//   than an end byte are still taken, and an end byte waits until the
//   result register is free or drains in the same cycle.
// Reset: synchronous, active low; returns to waiting for a start byte,
//   drops any pending result and restores the register defaults.
// The block never resynchronizes inside a frame: every byte is consumed by
//   its position, whatever its value.
// ----------------------------------------------------------------------------
module config_frame_validator import cfv_pkg::*; #(
    parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    cfv_rx_if.sink      i_rx,
    cfv_res_if.source   o_res,
    cfv_cfg_if.sink     i_cfg
);

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_ADDR  = 3'd1,
        PH_COUNT = 3'd2,
        PH_REC   = 3'd3,
        PH_CRC   = 3'd4,
        PH_END   = 3'd5
    } t_phase;

    // configuration registers
    logic [BYTE_W-1:0] r_start_flag;
    logic [BYTE_W-1:0] r_end_flag;
    logic [BYTE_W-1:0] r_board_address;

    // frame state
    t_phase                  r_phase,      n_phase;
    logic [BYTES_LEFT_W-1:0] r_bytes_left, n_bytes_left;
    logic [BYTE_W-1:0]       r_crc,        n_crc;
    logic                    r_start_bad,  n_start_bad;
    logic [BYTE_W-1:0]       r_seen_addr,  n_seen_addr;
    logic [BYTE_W-1:0]       r_seen_count, n_seen_count;
    logic                    r_crc_bad,    n_crc_bad;

    // result register
    logic              r_res_valid,  n_res_valid;
    t_status           r_res_status, n_res_status;
    logic [BYTE_W-1:0] r_res_addr,   n_res_addr;
    logic [BYTE_W-1:0] r_res_count,  n_res_count;

    logic              rx_take;
    logic              res_free;
    logic [BYTE_W-1:0] crc_next;
    logic [BYTES_LEFT_W-1:0] count_bytes;

    // the result slot is free when empty or drained this cycle
    assign res_free   = !r_res_valid || o_res.ready;
    // only the end byte needs room in the result register
    assign i_rx.ready = (r_phase != PH_END) || res_free;
    assign rx_take    = i_rx.valid && i_rx.ready;
    assign i_cfg.ready = 1'b1;

    assign count_bytes = BYTES_LEFT_W'(BYTES_LEFT_W'(i_rx.rx_byte)
                                       * BYTES_LEFT_W'(RECORD_BYTES));

    cfv_crc8 u_crc (
        .i_crc  (r_crc),
        .i_data (i_rx.rx_byte),
        .o_crc  (crc_next)
    );

    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_crc        = r_crc;
        n_start_bad  = r_start_bad;
        n_seen_addr  = r_seen_addr;
        n_seen_count = r_seen_count;
        n_crc_bad    = r_crc_bad;
        n_res_valid  = r_res_valid && !o_res.ready;
        n_res_status = r_res_status;
        n_res_addr   = r_res_addr;
        n_res_count  = r_res_count;

        if (rx_take) begin
            case (r_phase)
                PH_ADDR: begin
                    n_seen_addr = i_rx.rx_byte;
                    n_phase     = PH_COUNT;
                end
                PH_COUNT: begin
                    n_seen_count = i_rx.rx_byte;
                    n_bytes_left = count_bytes;
                    n_crc        = CRC_INIT;
                    n_phase      = (count_bytes == '0) ? PH_CRC : PH_REC;
                end
                PH_REC: begin
                    n_crc        = crc_next;
                    n_bytes_left = r_bytes_left - 1'b1;
                    if (n_bytes_left == '0) begin
                        n_phase = PH_CRC;
                    end
                end
                PH_CRC: begin
                    n_crc_bad = (i_rx.rx_byte != r_crc);
                    n_phase   = PH_END;
                end
                PH_END: begin
                    // pick the status in priority order
                    if (r_start_bad) begin
                        n_res_status = ST_BAD_START;
                    end else if (r_seen_addr != r_board_address) begin
                        n_res_status = ST_BAD_ADDR;
                    end else if (r_crc_bad) begin
                        n_res_status = ST_BAD_CRC;
                    end else if (i_rx.rx_byte != r_end_flag) begin
                        n_res_status = ST_BAD_END;
                    end else begin
                        n_res_status = ST_OK;
                    end
                    n_res_valid = 1'b1;
                    n_res_addr  = r_seen_addr;
                    n_res_count = r_seen_count;
                    n_phase     = PH_START;
                end
                default: begin
                    // start byte: flag a mismatch, report it with the end byte
                    n_start_bad  = (i_rx.rx_byte != r_start_flag);
                    n_crc        = CRC_INIT;
                    n_crc_bad    = 1'b0;
                    n_bytes_left = '0;
                    n_phase      = PH_ADDR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_flag    <= START_FLAG_RST;
            r_end_flag      <= END_FLAG_RST;
            r_board_address <= BOARD_ADDRESS_RST;
            r_phase         <= PH_START;
            r_bytes_left    <= '0;
            r_crc           <= CRC_INIT;
            r_start_bad     <= 1'b0;
            r_seen_addr     <= '0;
            r_seen_count    <= '0;
            r_crc_bad       <= 1'b0;
            r_res_valid     <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_START_FLAG:    r_start_flag    <= i_cfg.data;
                    REG_END_FLAG:      r_end_flag      <= i_cfg.data;
                    REG_BOARD_ADDRESS: r_board_address <= i_cfg.data;
                    default: begin
                        // drop writes outside the register list
                    end
                endcase
            end
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_crc        <= n_crc;
            r_start_bad  <= n_start_bad;
            r_seen_addr  <= n_seen_addr;
            r_seen_count <= n_seen_count;
            r_crc_bad    <= n_crc_bad;
            r_res_valid  <= n_res_valid;
        end
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        r_res_count  <= n_res_count;
    end

    assign o_res.valid         = r_res_valid;
    assign o_res.status        = r_res_status;
    assign o_res.frame_address = r_res_addr;
    assign o_res.record_count  = r_res_count;

    // a new result only follows an accepted end byte
    a_res_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(rx_take && r_phase == PH_END))
        else $error("result raised without an end byte");

    // an end byte never overwrites a result that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_take && r_phase == PH_END) |-> (!r_res_valid || o_res.ready))
        else $error("end byte taken over a pending result");

    // record phase always has bytes left to consume
    a_rec_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_REC) |-> (r_bytes_left != '0))
        else $error("record phase with no bytes left");

    // after an end byte the frame machine waits for a start byte
    a_end_to_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_take && r_phase == PH_END) |=> (r_phase == PH_START))
        else $error("frame state did not return to start");

endmodule

`default_nettype wire

// ===== sim/tb_config_frame_validator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_config_frame_validator
// Self-checking bench for the configuration frame validator. Frames are built
// byte by byte and pushed through the receive channel. A byte-level tracker
// of the frame state predicts one report per end byte. A separate process
// compares every result beat, field by field, against the oldest pending
// report. Both channel sides idle in random bursts, and the result side is
// held off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_config_frame_validator import cfv_pkg::*; ();

    localparam int RECORD_BYTES  = RECORD_BYTES_DEF;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int LONG_HOLD     = 200;     // result-side hold-off, in cycles
    localparam int PHASE_BEATS   = 20;      // random beats per register setting

    // position of the next byte within a frame
    typedef enum logic [2:0] {
        FR_START   = 3'd0,
        FR_ADDR    = 3'd1,
        FR_COUNT   = 3'd2,
        FR_RECORDS = 3'd3,
        FR_CRC     = 3'd4,
        FR_END     = 3'd5
    } t_frame_phase;

    // content of the record bytes of a built frame
    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } t_fill;

    // one frame report as the block should give it
    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] rec_count;
    } t_frame_report;

    logic clk;
    logic rst_n;

    cfv_rx_if  rx_bus  ();
    cfv_res_if res_bus ();
    cfv_cfg_if cfg_bus ();

    config_frame_validator #(
        .RECORD_BYTES (RECORD_BYTES)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    // tracked copy of the register file
    logic [BYTE_W-1:0] reg_start_flag;
    logic [BYTE_W-1:0] reg_end_flag;
    logic [BYTE_W-1:0] reg_board_addr;

    // tracked copy of the frame state
    t_frame_phase            trk_phase;
    logic [BYTES_LEFT_W-1:0] trk_left;
    logic [BYTE_W-1:0]       trk_crc;
    logic                    trk_start_bad;
    logic [BYTE_W-1:0]       trk_addr;
    logic [BYTE_W-1:0]       trk_count;
    logic                    trk_crc_bad;

    t_frame_report pending_reports[$];

    int mismatches   = 0;
    int rx_beats     = 0;
    int cycle_count  = 0;
    int hold_request = 0;
    bit bursts_on    = 1'b1;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin : clock_gen
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Advance a reflected CRC-8 by one byte, LSB first.
    function automatic logic [BYTE_W-1:0] crc8_step_lsb(input logic [BYTE_W-1:0] crc_in,
                                                        input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc_in;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0] ^ data[k]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Advance the tracked frame state by one accepted byte; on the end byte,
    // queue the report the block has to give.
    task automatic track_frame_byte(input logic [BYTE_W-1:0] b);
        t_frame_report rep;
        case (trk_phase)
            FR_ADDR: begin
                trk_addr  = b;
                trk_phase = FR_COUNT;
            end
            FR_COUNT: begin
                trk_count = b;
                trk_left  = BYTES_LEFT_W'(int'(b) * RECORD_BYTES);
                trk_crc   = CRC_INIT;
                if (trk_left == '0) begin
                    trk_phase = FR_CRC;
                end else begin
                    trk_phase = FR_RECORDS;
                end
            end
            FR_RECORDS: begin
                trk_crc  = crc8_step_lsb(trk_crc, b);
                trk_left = trk_left - 1'b1;
                if (trk_left == '0) begin
                    trk_phase = FR_CRC;
                end
            end
            FR_CRC: begin
                trk_crc_bad = (b != trk_crc);
                trk_phase   = FR_END;
            end
            FR_END: begin
                // priority: start, address, CRC, end flag
                if (trk_start_bad) begin
                    rep.status = ST_BAD_START;
                end else if (trk_addr != reg_board_addr) begin
                    rep.status = ST_BAD_ADDR;
                end else if (trk_crc_bad) begin
                    rep.status = ST_BAD_CRC;
                end else if (b != reg_end_flag) begin
                    rep.status = ST_BAD_END;
                end else begin
                    rep.status = ST_OK;
                end
                rep.address   = trk_addr;
                rep.rec_count = trk_count;
                pending_reports.push_back(rep);
                trk_phase = FR_START;
            end
            default: begin
                // a bad start byte still opens a frame
                trk_start_bad = (b != reg_start_flag);
                trk_crc       = CRC_INIT;
                trk_crc_bad   = 1'b0;
                trk_left      = '0;
                trk_phase     = FR_ADDR;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Offer one byte, optionally after an idle burst, and hold it until taken.
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        int gap;
        gap = 0;
        if (bursts_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 14);
        end
        if (gap > 0) begin
            rx_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= value;
        @(posedge clk);
        while (rx_bus.ready !== 1'b1) @(posedge clk);
        rx_beats++;
        track_frame_byte(value);
    endtask

    // Random byte; keep the count small when it lands on the count position.
    task automatic send_filler_byte();
        if (trk_phase == FR_COUNT) begin
            send_byte(BYTE_W'($urandom_range(0, 3)));
        end else begin
            send_byte(BYTE_W'($urandom));
        end
    endtask

    // Complete whatever frame the block is in the middle of.
    task automatic finish_frame();
        while (trk_phase != FR_START) send_filler_byte();
    endtask

    // Finish the frame in flight, drop valid, wait for every report to come
    // back and let the block settle.
    task automatic quiesce();
        finish_frame();
        rx_bus.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [BYTE_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (cfg_bus.ready !== 1'b1) @(posedge clk);
        case (idx)
            REG_START_FLAG:    reg_start_flag = value;
            REG_END_FLAG:      reg_end_flag   = value;
            REG_BOARD_ADDRESS: reg_board_addr = value;
            default: ;
        endcase
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [BYTE_W-1:0] sflag,
                                  input logic [BYTE_W-1:0] eflag,
                                  input logic [BYTE_W-1:0] addr);
        quiesce();
        write_reg(REG_START_FLAG, sflag);
        write_reg(REG_END_FLAG, eflag);
        write_reg(REG_BOARD_ADDRESS, addr);
    endtask

    // Build and send one frame; the CRC byte is either correct or corrupted.
    task automatic send_frame(input logic [BYTE_W-1:0] sflag,
                              input logic [BYTE_W-1:0] addr,
                              input logic [BYTE_W-1:0] count,
                              input t_fill           fill,
                              input bit              crc_good,
                              input logic [BYTE_W-1:0] eflag);
        logic [BYTE_W-1:0] crc;
        logic [BYTE_W-1:0] rec;
        int                n;
        crc = CRC_INIT;
        n   = int'(count) * RECORD_BYTES;
        send_byte(sflag);
        send_byte(addr);
        send_byte(count);
        for (int i = 0; i < n; i++) begin
            case (fill)
                FILL_ZERO: rec = '0;
                FILL_ONES: rec = '1;
                default:   rec = BYTE_W'($urandom);
            endcase
            crc = crc8_step_lsb(crc, rec);
            send_byte(rec);
        end
        if (crc_good) begin
            send_byte(crc);
        end else begin
            send_byte(crc ^ BYTE_W'($urandom_range(1, 255)));
        end
        send_byte(eflag);
    endtask

    // Mostly well-formed frames with random records; some carry one error,
    // some several, and a few are broken by stray bytes ahead of them.
    task automatic send_random_frame();
        logic [BYTE_W-1:0] sflag;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] eflag;
        logic [BYTE_W-1:0] count;
        bit                crc_good;
        int                pick;
        int                size_pick;
        sflag     = reg_start_flag;
        addr      = reg_board_addr;
        eflag     = reg_end_flag;
        crc_good  = 1'b1;
        pick      = $urandom_range(0, 99);
        size_pick = $urandom_range(0, 99);
        if (size_pick < 15) begin
            count = '0;
        end else if (size_pick < 90) begin
            count = BYTE_W'($urandom_range(1, 4));
        end else begin
            count = BYTE_W'($urandom_range(5, 12));
        end
        if (pick < 8) begin
            sflag ^= BYTE_W'($urandom_range(1, 255));
        end else if (pick < 16) begin
            addr ^= BYTE_W'($urandom_range(1, 255));
        end else if (pick < 24) begin
            crc_good = 1'b0;
        end else if (pick < 32) begin
            eflag ^= BYTE_W'($urandom_range(1, 255));
        end else if (pick < 38) begin
            sflag    = BYTE_W'($urandom);
            addr     = BYTE_W'($urandom);
            eflag    = BYTE_W'($urandom);
            crc_good = bit'($urandom_range(0, 1));
        end else if (pick < 45) begin
            // stray bytes throw the next frame off its positions
            repeat ($urandom_range(1, 6)) send_filler_byte();
        end
        send_frame(sflag, addr, count, FILL_RANDOM, crc_good, eflag);
        finish_frame();
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall bursts, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        int held;
        stall = 0;
        held  = 0;
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request > 0) begin
                held         = hold_request;
                hold_request = 0;
            end
            if (held > 0) begin
                held--;
                res_bus.ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
                if (bursts_on && $urandom_range(0, 7) == 0) begin
                    stall = $urandom_range(1, 14);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic check_field(input string what, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    initial begin : result_checker
        t_frame_report want;
        forever begin
            @(posedge clk);
            if (rst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
                if (pending_reports.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, expected none, actual %0d/%0d/%0d",
                             $time, res_bus.status, res_bus.frame_address,
                             res_bus.record_count);
                end else begin
                    want = pending_reports.pop_front();
                    check_field("status", BYTE_W'(want.status), BYTE_W'(res_bus.status));
                    check_field("frame_address", want.address, res_bus.frame_address);
                    check_field("record_count", want.rec_count, res_bus.record_count);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("config_frame_validator verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // One frame per status under the reset register values. Each bad frame
    // but the bad-end one also carries lower-priority errors to prove the ordering;
    // zero-record frames check that the CRC byte follows the count directly.
    task automatic test_frame_status();
        send_frame(START_FLAG_RST, BOARD_ADDRESS_RST, 8'd1, FILL_RANDOM, 1'b1,
                   END_FLAG_RST);
        send_frame(8'h00, 8'hFF, 8'd0, FILL_ZERO, 1'b0, 8'h00);
        send_frame(START_FLAG_RST, 8'hFF, 8'd1, FILL_ONES, 1'b0, END_FLAG_RST);
        send_frame(START_FLAG_RST, BOARD_ADDRESS_RST, 8'd0, FILL_ZERO, 1'b0, 8'hFF);
        send_frame(START_FLAG_RST, BOARD_ADDRESS_RST, 8'd0, FILL_ZERO, 1'b1, 8'hFF);
    endtask

    // Register extremes, equal start and end flags, and back to the defaults.
    task automatic test_register_settings();
        logic [BYTE_W-1:0] settings [4][3];
        settings = '{'{8'h00, 8'hFF, 8'h00},
                     '{8'hFF, 8'h00, 8'hFF},
                     '{8'h5A, 8'h5A, 8'h80},
                     '{START_FLAG_RST, END_FLAG_RST, BOARD_ADDRESS_RST}};
        for (int s = 0; s < 4; s++) begin
            apply_settings(settings[s][0], settings[s][1], settings[s][2]);
            send_frame(reg_start_flag, reg_board_addr, 8'd0, FILL_RANDOM, 1'b1,
                       reg_end_flag);
            send_frame(reg_start_flag, reg_board_addr, 8'd2, FILL_RANDOM, 1'b1,
                       reg_end_flag);
            send_frame(reg_start_flag, reg_board_addr, 8'd1, FILL_RANDOM, 1'b1,
                       ~reg_end_flag);
        end
    endtask

    // Hold the result side off while short frames keep coming: the result
    // register fills and the next end byte has to wait. Then pause the
    // sender until every report is back before going on.
    task automatic test_result_backpressure();
        quiesce();
        bursts_on    = 1'b0;
        hold_request = LONG_HOLD;
        repeat (6) begin
            send_frame(reg_start_flag, reg_board_addr, 8'd0, FILL_RANDOM, 1'b1,
                       reg_end_flag);
        end
        quiesce();
        bursts_on = 1'b1;
        repeat (4) send_random_frame();
        quiesce();
    endtask

    // Largest record count: the byte counter starts from 765, its largest load.
    task automatic test_longest_frame();
        send_frame(reg_start_flag, reg_board_addr, 8'd255, FILL_RANDOM, 1'b1,
                   reg_end_flag);
    endtask

    // Random frames under several random register settings.
    task automatic test_random_frames();
        int goal;
        for (int p = 0; p < 4; p++) begin
            apply_settings(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
            goal = rx_beats + PHASE_BEATS;
            while (rx_beats < goal) send_random_frame();
        end
    endtask

    // Closing stretch with no idling on either side: frames back to back.
    task automatic test_back_to_back();
        bursts_on = 1'b0;
        repeat (5) send_random_frame();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        rx_bus.valid   <= 1'b0;
        rx_bus.rx_byte <= '0;
        cfg_bus.valid  <= 1'b0;
        cfg_bus.index  <= REG_START_FLAG;
        cfg_bus.data   <= '0;
        rst_n          <= 1'b0;

        // tracked state starts from the reset values
        reg_start_flag = START_FLAG_RST;
        reg_end_flag   = END_FLAG_RST;
        reg_board_addr = BOARD_ADDRESS_RST;
        trk_phase      = FR_START;
        trk_left       = '0;
        trk_crc        = CRC_INIT;
        trk_start_bad  = 1'b0;
        trk_addr       = '0;
        trk_count      = '0;
        trk_crc_bad    = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_frame_status();
        test_register_settings();
        test_result_backpressure();
        test_longest_frame();
        test_random_frames();
        test_back_to_back();

        quiesce();
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("config_frame_validator verification clean");
        end else begin
            $display("config_frame_validator verification failed");
        end
        $finish;
    end

endmodule
